// ===== rtl/smf_pkg.sv =====
// ---------------------------------------------------------------------------
// smf_pkg
// Shared types and constants for the switching median RGB filter.
// ---------------------------------------------------------------------------
package smf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_WINDOW = 7;
   localparam int MAX_HEIGHT = 1024;

   localparam int PIX_W     = 8;
   localparam int RGB_W     = 3 * PIX_W;
   localparam int POS_W     = 10;
   localparam int CFG_W     = 11;
   localparam int RAD_W     = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_RADIUS = 2'd2;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
   localparam logic [RAD_W-1:0] RADIUS_RESET = 2'd1;

   typedef logic [RGB_W-1:0] rgb_type;

   // status a sorter cell shows its right-hand neighbor
   typedef struct packed {
      logic       valid;
      logic [2:0] keep;
   } link_type;

endpackage

// ===== rtl/smf_channels.sv =====
// ---------------------------------------------------------------------------
// smf channels
// Pixel, result and register-write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface smf_pix_if;
   logic                       valid;
   logic                       ready;
   logic [smf_pkg::PIX_W-1:0]  pix_blue;
   logic [smf_pkg::PIX_W-1:0]  pix_green;
   logic [smf_pkg::PIX_W-1:0]  pix_red;
   logic                       frame_start;
   modport source (output valid, pix_blue, pix_green, pix_red, frame_start, input ready);
   modport sink   (input valid, pix_blue, pix_green, pix_red, frame_start, output ready);
endinterface

interface smf_res_if;
   logic                       valid;
   logic                       ready;
   logic [smf_pkg::POS_W-1:0]  out_row;
   logic [smf_pkg::POS_W-1:0]  out_col;
   logic [smf_pkg::PIX_W-1:0]  out_blue;
   logic [smf_pkg::PIX_W-1:0]  out_green;
   logic [smf_pkg::PIX_W-1:0]  out_red;
   logic                       replaced;
   modport source (output valid, out_row, out_col, out_blue, out_green, out_red, replaced,
                   input ready);
   modport sink   (input valid, out_row, out_col, out_blue, out_green, out_red, replaced,
                   output ready);
endinterface

interface smf_csr_if;
   logic                          valid;
   logic                          ready;
   logic [smf_pkg::CSR_IDX_W-1:0] index;
   logic [smf_pkg::CFG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/switching_median_rgb_filter_core.sv =====
// ---------------------------------------------------------------------------
// switching_median_rgb_filter_core
// Switching median filter over a raster RGB stream with line storage.
// ---------------------------------------------------------------------------
// A pixel whose window is not complete (border rows and columns) is taken
// without a window fetch; the core stays ready for the next pixel. For a
// pixel that completes a window, the window is read from the line store one
// pixel per cycle through its single read port and fed into a chain of
// insertion-sort cells, then the result is loaded into the output register;
// loading waits while an earlier result is still held there. The line store
// has no clearing pass after reset.
module switching_median_rgb_filter_core #(
   parameter int MAX_WIDTH  = smf_pkg::MAX_WIDTH,
   parameter int MAX_WINDOW = smf_pkg::MAX_WINDOW
) (
   input  logic       clock,
   input  logic       reset,
   smf_pix_if.sink    req_bus,
   smf_res_if.source  rsp_bus,
   smf_csr_if.sink    csr_bus
);

   localparam int MAX_RADIUS = (MAX_WINDOW - 1) / 2;
   localparam int CELLS = MAX_WINDOW * MAX_WINDOW;
   localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = ($clog2(MAX_WIDTH + 1) > smf_pkg::CFG_W) ?
                        $clog2(MAX_WIDTH + 1) : smf_pkg::CFG_W;
   localparam int SW  = $clog2(MAX_WINDOW);
   localparam int SDW = $clog2(MAX_WINDOW + 1);
   localparam int RW  = $clog2(MAX_RADIUS + 1);
   localparam int NW  = $clog2(CELLS + 1);
   localparam int CIW = $clog2(CELLS);
   localparam int PW  = smf_pkg::POS_W;
   localparam int XW  = smf_pkg::PIX_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   // registers
   logic [smf_pkg::CFG_W-1:0] width_ff, height_ff;
   logic [smf_pkg::RAD_W-1:0] radius_ff;
   logic [PW-1:0]  row_ff, row_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [SW-1:0]  slot_ff, slot_in;
   logic [1:0]     state_ff;
   logic [AW-1:0]  rdbase_ff;
   logic [SW-1:0]  rdslot_ff;
   logic [CW-1:0]  col0_ff;
   logic [SDW-1:0] dx_ff, dy_ff, side_ff;
   logic [RW-1:0]  rad_ff;
   logic [CIW-1:0] med_idx_ff, max_idx_ff;
   logic [PW-1:0]  crow_ff, ccol_ff;
   logic           rd_valid_ff, rd_center_ff;
   smf_pkg::rgb_type center_ff;
   logic           rsp_valid_ff;
   logic [PW-1:0]  rsp_row_ff, rsp_col_ff;
   smf_pkg::rgb_type rsp_pix_ff;
   logic           rsp_rep_ff;

   // decoded configuration
   logic [WW-1:0]             w_eff;
   logic [smf_pkg::CFG_W-1:0] h_eff;
   logic [RW-1:0]             rad;
   logic [SDW-1:0]            span, side;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (WW'(width_ff) > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = smf_pkg::CFG_W'(1);
      end else if (height_ff > smf_pkg::CFG_W'(smf_pkg::MAX_HEIGHT)) begin
         h_eff = smf_pkg::CFG_W'(smf_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      if (radius_ff == '0) begin
         rad = RW'(1);
      end else if (4'(radius_ff) > 4'(MAX_RADIUS)) begin
         rad = RW'(MAX_RADIUS);
      end else begin
         rad = RW'(radius_ff);
      end
      span = SDW'({rad, 1'b0});
      side = span + SDW'(1);
   end

   // raster position of the incoming beat
   logic           req_fire, restart_row, c_last, r_last, emit;
   logic [PW-1:0]  r0;
   logic [CW-1:0]  c0;
   logic [SW-1:0]  slot0, slot_top;
   logic [AW-1:0]  wr_addr;
   logic [NW-1:0]  nn;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      restart_row = req_bus.frame_start || ({1'b0, row_ff} >= h_eff);
      r0    = restart_row ? '0 : row_ff;
      slot0 = restart_row ? '0 : slot_ff;
      c0    = (req_bus.frame_start || (WW'(col_ff) >= w_eff)) ? '0 : col_ff;
      emit  = (32'(r0) >= 32'(span)) && (32'(c0) >= 32'(span));
      c_last = (WW'(c0) + WW'(1)) >= w_eff;
      r_last = ({1'b0, r0} + smf_pkg::CFG_W'(1)) >= h_eff;
      col_in  = c_last ? '0 : c0 + CW'(1);
      row_in  = r0;
      slot_in = slot0;
      if (c_last) begin
         row_in  = r_last ? '0 : r0 + PW'(1);
         slot_in = (r_last || (32'(slot0) == MAX_WINDOW - 1)) ? '0 : slot0 + SW'(1);
      end
      slot_top = (32'(slot0) >= 32'(span)) ? SW'(32'(slot0) - 32'(span)) :
                 SW'(32'(slot0) + MAX_WINDOW - 32'(span));
      wr_addr = AW'(32'(slot0) * MAX_WIDTH) + AW'(c0);
      nn      = NW'(32'(side) * 32'(side));
   end

   // window read sequencing
   logic           x_last, y_last, at_center, out_free, hit;
   logic [AW-1:0]  rd_addr;
   smf_pkg::rgb_type ram_q, med_val, min_val, max_val;

   always_comb begin
      x_last    = (dx_ff == side_ff - SDW'(1));
      y_last    = (dy_ff == side_ff - SDW'(1));
      at_center = (dx_ff == SDW'(rad_ff)) && (dy_ff == SDW'(rad_ff));
      rd_addr   = rdbase_ff + AW'(CW'(col0_ff + CW'(dx_ff)));
      out_free  = !rsp_valid_ff || rsp_bus.ready;
      hit = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if ((center_ff[k*XW +: XW] == min_val[k*XW +: XW]) ||
             (center_ff[k*XW +: XW] == max_val[k*XW +: XW])) begin
            hit = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= smf_pkg::WIDTH_RESET;
         height_ff    <= smf_pkg::HEIGHT_RESET;
         radius_ff    <= smf_pkg::RADIUS_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         slot_ff      <= '0;
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rd_center_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               smf_pkg::CSR_IMAGE_WIDTH:   width_ff  <= csr_bus.data;
               smf_pkg::CSR_IMAGE_HEIGHT:  height_ff <= csr_bus.data;
               smf_pkg::CSR_WINDOW_RADIUS: radius_ff <= csr_bus.data[smf_pkg::RAD_W-1:0];
               default: ;
            endcase
         end
         rd_valid_ff  <= (state_ff == ST_READ);
         rd_center_ff <= (state_ff == ST_READ) && at_center;
         if ((state_ff == ST_FIN) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  row_ff  <= row_in;
                  col_ff  <= col_in;
                  slot_ff <= slot_in;
                  if (emit) begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               if (x_last && y_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end

      // datapath
      if (req_fire) begin
         rdbase_ff  <= AW'(32'(slot_top) * MAX_WIDTH);
         rdslot_ff  <= slot_top;
         col0_ff    <= c0 - CW'(span);
         dx_ff      <= '0;
         dy_ff      <= '0;
         side_ff    <= side;
         rad_ff     <= rad;
         med_idx_ff <= CIW'((nn - NW'(1)) >> 1);
         max_idx_ff <= CIW'(nn - NW'(1));
         crow_ff    <= PW'(32'(r0) - 32'(rad));
         ccol_ff    <= PW'(32'(c0) - 32'(rad));
      end else if (state_ff == ST_READ) begin
         if (x_last) begin
            dx_ff <= '0;
            dy_ff <= dy_ff + SDW'(1);
            if (32'(rdslot_ff) == MAX_WINDOW - 1) begin
               rdslot_ff <= '0;
               rdbase_ff <= '0;
            end else begin
               rdslot_ff <= rdslot_ff + SW'(1);
               rdbase_ff <= rdbase_ff + AW'(MAX_WIDTH);
            end
         end else begin
            dx_ff <= dx_ff + SDW'(1);
         end
      end
      if (rd_center_ff) begin
         center_ff <= ram_q;
      end
      if ((state_ff == ST_FIN) && out_free) begin
         rsp_row_ff <= crow_ff;
         rsp_col_ff <= ccol_ff;
         rsp_pix_ff <= hit ? med_val : center_ff;
         rsp_rep_ff <= hit;
      end
   end

   smf_ram #(
      .WIDTH (smf_pkg::RGB_W),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (wr_addr),
      .wr_data ({req_bus.pix_red, req_bus.pix_green, req_bus.pix_blue}),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   smf_sort_chain #(
      .CELLS (CELLS)
   ) u_sort (
      .clock   (clock),
      .reset   (reset),
      .clear   (req_fire && emit),
      .insert  (rd_valid_ff),
      .pix     (ram_q),
      .med_idx (med_idx_ff),
      .max_idx (max_idx_ff),
      .med_val (med_val),
      .min_val (min_val),
      .max_val (max_val)
   );

   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_row   = rsp_row_ff;
   assign rsp_bus.out_col   = rsp_col_ff;
   assign rsp_bus.out_blue  = rsp_pix_ff[XW-1:0];
   assign rsp_bus.out_green = rsp_pix_ff[2*XW-1:XW];
   assign rsp_bus.out_red   = rsp_pix_ff[3*XW-1:2*XW];
   assign rsp_bus.replaced  = rsp_rep_ff;

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) && out_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished window did not load the output register");

   a_rd_in_window: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_READ) || (state_ff == ST_DRAIN))
      else $error("line store read beat outside window fetch");

   a_emit_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && emit |=> (state_ff == ST_READ))
      else $error("complete window did not start a fetch");

   a_border_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && !emit |=> (state_ff == ST_IDLE) && !rd_valid_ff)
      else $error("border pixel started a fetch");

endmodule

// ===== rtl/smf_ram.sv =====
// ---------------------------------------------------------------------------
// smf_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module smf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/smf_sort_cell.sv =====
// ---------------------------------------------------------------------------
// smf_sort_cell
// One insertion-sort cell: holds one sorted entry per color channel.
// ---------------------------------------------------------------------------
module smf_sort_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              insert,
   input  smf_pkg::rgb_type  pix,
   input  smf_pkg::rgb_type  left_val,
   input  smf_pkg::link_type left_lnk,
   output smf_pkg::rgb_type  val,
   output smf_pkg::link_type lnk
);

   smf_pkg::rgb_type val_ff, val_in;
   logic             valid_ff, valid_in;
   logic [2:0]       keep;

   always_comb begin
      val_in = val_ff;
      for (int k = 0; k < 3; k++) begin
         keep[k] = valid_ff && (val_ff[k*smf_pkg::PIX_W +: smf_pkg::PIX_W] <=
                                pix[k*smf_pkg::PIX_W +: smf_pkg::PIX_W]);
         if (!keep[k]) begin
            val_in[k*smf_pkg::PIX_W +: smf_pkg::PIX_W] = left_lnk.keep[k] ?
               pix[k*smf_pkg::PIX_W +: smf_pkg::PIX_W] :
               left_val[k*smf_pkg::PIX_W +: smf_pkg::PIX_W];
         end
      end
      valid_in = clear ? 1'b0 : (insert ? (valid_ff | left_lnk.valid) : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (insert) begin
         val_ff <= val_in;
      end
   end

   assign val       = val_ff;
   assign lnk.valid = valid_ff;
   assign lnk.keep  = keep;

endmodule

// ===== rtl/smf_sort_chain.sv =====
// ---------------------------------------------------------------------------
// smf_sort_chain
// Row of sort cells; one pixel inserted per beat, all channels in parallel.
// ---------------------------------------------------------------------------
module smf_sort_chain #(
   parameter int CELLS = 49
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     insert,
   input  smf_pkg::rgb_type         pix,
   input  logic [$clog2(CELLS)-1:0] med_idx,
   input  logic [$clog2(CELLS)-1:0] max_idx,
   output smf_pkg::rgb_type         med_val,
   output smf_pkg::rgb_type         min_val,
   output smf_pkg::rgb_type         max_val
);

   smf_pkg::rgb_type  vals [CELLS];
   smf_pkg::link_type lnks [CELLS];
   smf_pkg::link_type head_lnk;

   assign head_lnk.valid = 1'b1;
   assign head_lnk.keep  = 3'b111;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      smf_sort_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (clear),
         .insert   (insert),
         .pix      (pix),
         .left_val ((i == 0) ? pix : vals[(i == 0) ? 0 : i-1]),
         .left_lnk ((i == 0) ? head_lnk : lnks[(i == 0) ? 0 : i-1]),
         .val      (vals[i]),
         .lnk      (lnks[i])
      );
   end

   assign min_val = vals[0];
   assign med_val = vals[med_idx];
   assign max_val = vals[max_idx];

endmodule
